### hw/rtl/cmsp_pkg.sv
// cmsp_pkg: shared constants, codes and types for the crop montage shelf placer
// used by the channel interfaces and the top level; depends on nothing

package cmsp_pkg;

  // box coordinate width and the start offset of every page cursor
  localparam int COORD_BITS   = 16;
  localparam int START_OFFSET = 15;

  // fixed widths of registers and result fields
  localparam int DIM_BITS   = 14;
  localparam int GAP_BITS   = 10;
  localparam int CUR_BITS   = 15;
  localparam int COUNT_BITS = 16;
  localparam int STAT_BITS  = 2;

  // intermediate widths: signed compare room and cursor sum room
  localparam int EXT_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;
  localparam int SUM_BITS = CUR_BITS + 2;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = DIM_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAP          = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd4;

  // register reset values
  localparam logic [DIM_BITS-1:0] PAGE_WIDTH_RESET   = 14'd1024;
  localparam logic [DIM_BITS-1:0] PAGE_HEIGHT_RESET  = 14'd1024;
  localparam logic [GAP_BITS-1:0] GAP_RESET          = 10'd15;
  localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RESET  = 14'd1024;
  localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RESET = 14'd1024;

  // action codes
  localparam logic ACT_PLACE  = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // status codes
  localparam logic [STAT_BITS-1:0] ST_PLACED   = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_EXCLUDED = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_DROPPED  = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_FINISHED = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // one result word
  typedef struct packed {
    logic [STAT_BITS-1:0]  status;
    logic [DIM_BITS-1:0]   source_x;
    logic [DIM_BITS-1:0]   source_y;
    logic [DIM_BITS-1:0]   crop_width;
    logic [DIM_BITS-1:0]   crop_height;
    logic [CUR_BITS-1:0]   place_x;
    logic [CUR_BITS-1:0]   place_y;
    logic [COUNT_BITS-1:0] page_number;
    logic [COUNT_BITS-1:0] counted_boxes;
  } result_t;

endpackage

### hw/rtl/cmsp_if.sv
// cmsp_box_if and cmsp_result_if: valid/ready channels of the shelf placer
// depends on cmsp_pkg for field widths

interface cmsp_box_if
  import cmsp_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] box_left;
  logic signed [COORD_BITS-1:0] box_top;
  logic signed [COORD_BITS-1:0] box_right;
  logic signed [COORD_BITS-1:0] box_bottom;

  modport source (output valid, action, box_left, box_top, box_right, box_bottom,
                  input ready);
  modport sink (input valid, action, box_left, box_top, box_right, box_bottom,
                output ready);
endinterface

interface cmsp_result_if
  import cmsp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [STAT_BITS-1:0]  status;
  logic [DIM_BITS-1:0]   source_x;
  logic [DIM_BITS-1:0]   source_y;
  logic [DIM_BITS-1:0]   crop_width;
  logic [DIM_BITS-1:0]   crop_height;
  logic [CUR_BITS-1:0]   place_x;
  logic [CUR_BITS-1:0]   place_y;
  logic [COUNT_BITS-1:0] page_number;
  logic [COUNT_BITS-1:0] counted_boxes;

  modport source (output valid, status, source_x, source_y, crop_width, crop_height,
                  place_x, place_y, page_number, counted_boxes,
                  input ready);
  modport sink (input valid, status, source_x, source_y, crop_width, crop_height,
                place_x, place_y, page_number, counted_boxes,
                output ready);
endinterface

### hw/rtl/crop_montage_shelf_placer.sv
// crop_montage_shelf_placer: shelf packing of detection crops onto montage pages
// depends on cmsp_pkg and the channel interfaces in cmsp_if.sv
//
// Usage
//   box (sink): one word per detection box or finish command. A place word
//     is checked against the page size, clipped to the source image and
//     packed left to right in rows; a finish word closes the current page.
//   result (source): exactly one word per box word, in order: status, clip
//     origin and size, paste position, page number and running box count.
//   cfg_we/cfg_index/cfg_data: register writes, taken at any edge with
//     cfg_we high; write only while no box word is in flight.
// Intake
//   a result word is registered into the result or, under stall, skid register;
//   one box word per cycle is taken while box.ready is high, set by the cursor
//   update loop (clip, row wrap and page-full check feed the cursor registers directly).
// Stall behavior
//   a two-entry output buffer (result register plus skid register) keeps
//   box.ready high while one finished word waits; box.ready drops only when
//   both entries are full.
// Reset
//   rst clears the buffer, sets cursors to the start offset, counters to zero
//   and registers to their defaults; the block is ready the next cycle.

module crop_montage_shelf_placer
  import cmsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  cmsp_box_if.sink                  box,
  cmsp_result_if.source             result
);

  // configuration registers
  logic [DIM_BITS-1:0] page_width;
  logic [DIM_BITS-1:0] page_height;
  logic [GAP_BITS-1:0] gap;
  logic [DIM_BITS-1:0] image_width;
  logic [DIM_BITS-1:0] image_height;

  // packing state
  logic [CUR_BITS-1:0]   cursor_x, cursor_x_next;
  logic [CUR_BITS-1:0]   cursor_y, cursor_y_next;
  logic [CUR_BITS-1:0]   row_height, row_height_next;
  logic [COUNT_BITS-1:0] page_count, page_count_next;
  logic [COUNT_BITS-1:0] box_count, box_count_next;

  // output buffer
  result_t out_data, skid_data, res_next;
  logic    out_valid, skid_valid;
  logic    accept, take;

  // per-word datapath
  logic signed [EXT_BITS-1:0] x1, y1, x2, y2;
  logic signed [EXT_BITS-1:0] pw_s, ph_s, iw_s, ih_s;
  logic signed [EXT_BITS-1:0] clip_r, clip_b;
  logic                       excluded, clip_ok;
  logic [DIM_BITS-1:0]        sx, sy, cw, ch;
  logic [SUM_BITS-1:0]        wrap_sum, y_row, y_need;
  logic [CUR_BITS-1:0]        x_row;
  logic                       wrap, full;
  logic [CUR_BITS:0]          row_need;
  logic [COUNT_BITS-1:0]      page_count_sat;

  assign box.ready = !skid_valid;
  assign accept    = box.valid && box.ready;
  assign take      = out_valid && result.ready;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      page_width   <= PAGE_WIDTH_RESET;
      page_height  <= PAGE_HEIGHT_RESET;
      gap          <= GAP_RESET;
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAGE_WIDTH:   page_width   <= cfg_data;
        REG_PAGE_HEIGHT:  page_height  <= cfg_data;
        REG_GAP:          gap          <= cfg_data[GAP_BITS-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge exclusion and clip against the source image
  always_comb begin
    x1   = EXT_BITS'(box.box_left);
    y1   = EXT_BITS'(box.box_top);
    x2   = EXT_BITS'(box.box_right);
    y2   = EXT_BITS'(box.box_bottom);
    pw_s = signed'(EXT_BITS'(page_width));
    ph_s = signed'(EXT_BITS'(page_height));
    iw_s = signed'(EXT_BITS'(image_width));
    ih_s = signed'(EXT_BITS'(image_height));

    excluded = (x1 < 0) || (x2 > pw_s) || (y1 < 0) || (y2 > ph_s);

    clip_r  = (x2 < iw_s) ? x2 : iw_s;
    clip_b  = (y2 < ih_s) ? y2 : ih_s;
    clip_ok = (clip_r > x1) && (clip_b > y1);

    sx = clip_ok ? DIM_BITS'(x1) : '0;
    sy = clip_ok ? DIM_BITS'(y1) : '0;
    cw = clip_ok ? DIM_BITS'(clip_r - x1) : '0;
    ch = clip_ok ? DIM_BITS'(clip_b - y1) : '0;
  end

  // row wrap and page-full check
  always_comb begin
    wrap_sum = SUM_BITS'(cursor_x) + (SUM_BITS'(cw) << 1);
    wrap     = wrap_sum > SUM_BITS'(page_width);
    x_row    = wrap ? CUR_BITS'(START_OFFSET) : cursor_x;
    y_row    = wrap ? (SUM_BITS'(cursor_y) + SUM_BITS'(row_height) + SUM_BITS'(gap))
                    : SUM_BITS'(cursor_y);
    y_need   = y_row + SUM_BITS'(ch);
    full     = y_need > SUM_BITS'(page_height);
    row_need = (CUR_BITS+1)'(ch) + (CUR_BITS+1)'(START_OFFSET);
    page_count_sat = (page_count != COUNT_MAX) ? page_count + 1'b1 : page_count;
  end

  // next state and result word
  always_comb begin
    cursor_x_next   = cursor_x;
    cursor_y_next   = cursor_y;
    row_height_next = row_height;
    page_count_next = page_count;
    box_count_next  = box_count;

    res_next             = '0;
    res_next.page_number = page_count;

    if (box.action == ACT_FINISH) begin
      res_next.status = ST_FINISHED;
      page_count_next = page_count_sat;
      cursor_x_next   = CUR_BITS'(START_OFFSET);
      cursor_y_next   = CUR_BITS'(START_OFFSET);
      row_height_next = CUR_BITS'(START_OFFSET);
    end else if (excluded) begin
      res_next.status = ST_EXCLUDED;
    end else begin
      if (box_count != COUNT_MAX) begin
        box_count_next = box_count + 1'b1;
      end
      res_next.source_x    = sx;
      res_next.source_y    = sy;
      res_next.crop_width  = cw;
      res_next.crop_height = ch;
      if (full) begin
        res_next.status = ST_DROPPED;
        page_count_next = page_count_sat;
        cursor_x_next   = CUR_BITS'(START_OFFSET);
        cursor_y_next   = CUR_BITS'(START_OFFSET);
        row_height_next = CUR_BITS'(START_OFFSET);
      end else begin
        res_next.status  = ST_PLACED;
        res_next.place_x = x_row;
        res_next.place_y = CUR_BITS'(y_row);
        cursor_x_next    = CUR_BITS'(SUM_BITS'(x_row) + SUM_BITS'(cw) + SUM_BITS'(gap));
        cursor_y_next    = CUR_BITS'(y_row);
        if ((CUR_BITS+1)'(row_height) < row_need) begin
          row_height_next = CUR_BITS'(row_need);
        end
      end
    end
    res_next.counted_boxes = box_count_next;
  end

  // packing state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= CUR_BITS'(START_OFFSET);
      cursor_y   <= CUR_BITS'(START_OFFSET);
      row_height <= CUR_BITS'(START_OFFSET);
      page_count <= '0;
      box_count  <= '0;
    end else if (accept) begin
      cursor_x   <= cursor_x_next;
      cursor_y   <= cursor_y_next;
      row_height <= row_height_next;
      page_count <= page_count_next;
      box_count  <= box_count_next;
    end
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // output buffer data
  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      out_data <= skid_valid ? skid_data : res_next;
    end else if (accept) begin
      skid_data <= res_next;
    end
  end

  // result word
  assign result.valid         = out_valid;
  assign result.status        = out_data.status;
  assign result.source_x      = out_data.source_x;
  assign result.source_y      = out_data.source_y;
  assign result.crop_width    = out_data.crop_width;
  assign result.crop_height   = out_data.crop_height;
  assign result.place_x       = out_data.place_x;
  assign result.place_y       = out_data.place_y;
  assign result.page_number   = out_data.page_number;
  assign result.counted_boxes = out_data.counted_boxes;

  // the skid entry is only ever filled behind a waiting result word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without a result word");

  // a waiting word with a full skid entry is never overwritten by a new box
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && skid_valid && !result.ready) |=> (out_valid && skid_valid))
    else $error("buffered result word lost under stall");

  // a stored cursor row never exceeds the largest page height
  a_cursor_y_range: assert property (@(posedge clk) disable iff (rst)
    cursor_y[CUR_BITS-1] == 1'b0)
    else $error("cursor_y beyond page height range");

  // page and box counters never step backward outside reset
  a_counts_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((page_count >= $past(page_count)) && (box_count >= $past(box_count))))
    else $error("counter decreased");

endmodule
